// ----- rtl/sic_pkg.sv -----
package sic_pkg;

    localparam int COORD_BITS = 20;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * COORD_BITS + 2;
    localparam int CROSS_BITS = 2 * COORD_BITS + 3;
    localparam int MAG_BITS   = 2 * COORD_BITS + 2;
    localparam int NUM_BITS   = 3 * COORD_BITS + 5;
    localparam int LATENCY    = 8 + COORD_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [CROSS_BITS-1:0] t_cross;
    typedef logic [MAG_BITS-1:0]          t_mag;
    typedef logic [NUM_BITS-1:0]          t_num;
    typedef logic [COORD_BITS-1:0]        t_quot;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_POINT   = 2'd1,
        KIND_OVERLAP = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind  kind;
        logic   proper;
        logic   bad;
        t_coord fx;
        t_coord fy;
        t_coord sx;
        t_coord sy;
        t_coord p1x;
        t_coord p1y;
        logic   negx;
        logic   negy;
    } t_pay;

    typedef struct packed {
        logic  valid;
        t_pay  pay;
        t_num  rx;
        t_num  ry;
        t_num  d;
        t_quot qx;
        t_quot qy;
    } t_cell;

endpackage

// ----- rtl/sic_front.sv -----
module sic_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sic_pkg::t_coord i_p1x,
    input  sic_pkg::t_coord i_p1y,
    input  sic_pkg::t_coord i_p2x,
    input  sic_pkg::t_coord i_p2y,
    input  sic_pkg::t_coord i_q1x,
    input  sic_pkg::t_coord i_q1y,
    input  sic_pkg::t_coord i_q2x,
    input  sic_pkg::t_coord i_q2y,
    output sic_pkg::t_cell  o_cell
);
    import sic_pkg::*;

    // stage a: captured coordinates
    logic   r_va;
    t_coord r_p1x, r_p1y, r_p2x, r_p2y, r_q1x, r_q1y, r_q2x, r_q2y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
        r_p1x <= i_p1x; r_p1y <= i_p1y; r_p2x <= i_p2x; r_p2y <= i_p2y;
        r_q1x <= i_q1x; r_q1y <= i_q1y; r_q2x <= i_q2x; r_q2y <= i_q2y;
    end

    // stage b: differences and box tests
    function automatic logic in_box(t_coord ax, t_coord ay, t_coord bx, t_coord by,
                                    t_coord px, t_coord py);
        t_coord x0, x1, y0, y1;
        x0 = (ax < bx) ? ax : bx;
        x1 = (ax < bx) ? bx : ax;
        y0 = (ay < by) ? ay : by;
        y1 = (ay < by) ? by : ay;
        return (px >= x0) && (px <= x1) && (py >= y0) && (py <= y1);
    endfunction

    function automatic t_diff sub(t_coord a, t_coord b);
        return t_diff'(a) - t_diff'(b);
    endfunction

    logic   n_boxes;
    logic   r_vb, r_boxes, r_bq1, r_bq2, r_bp1, r_bp2;
    t_coord r_bp1x, r_bp1y, r_bp2x, r_bp2y, r_bq1x, r_bq1y, r_bq2x, r_bq2y;
    t_diff  r_dx, r_dy, r_ex, r_ey, r_wx, r_wy, r_vx, r_vy, r_ux, r_uy, r_tx, r_ty;

    always_comb begin
        n_boxes = !(((r_p1x < r_p2x) ? r_p1x : r_p2x) > ((r_q1x > r_q2x) ? r_q1x : r_q2x) ||
                    ((r_p1x > r_p2x) ? r_p1x : r_p2x) < ((r_q1x < r_q2x) ? r_q1x : r_q2x) ||
                    ((r_p1y < r_p2y) ? r_p1y : r_p2y) > ((r_q1y > r_q2y) ? r_q1y : r_q2y) ||
                    ((r_p1y > r_p2y) ? r_p1y : r_p2y) < ((r_q1y < r_q2y) ? r_q1y : r_q2y));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_boxes <= n_boxes;
        r_bq1 <= in_box(r_p1x, r_p1y, r_p2x, r_p2y, r_q1x, r_q1y);
        r_bq2 <= in_box(r_p1x, r_p1y, r_p2x, r_p2y, r_q2x, r_q2y);
        r_bp1 <= in_box(r_q1x, r_q1y, r_q2x, r_q2y, r_p1x, r_p1y);
        r_bp2 <= in_box(r_q1x, r_q1y, r_q2x, r_q2y, r_p2x, r_p2y);
        r_bp1x <= r_p1x; r_bp1y <= r_p1y; r_bp2x <= r_p2x; r_bp2y <= r_p2y;
        r_bq1x <= r_q1x; r_bq1y <= r_q1y; r_bq2x <= r_q2x; r_bq2y <= r_q2y;
        r_dx <= sub(r_p2x, r_p1x); r_dy <= sub(r_p2y, r_p1y);
        r_ex <= sub(r_q2x, r_q1x); r_ey <= sub(r_q2y, r_q1y);
        r_wx <= sub(r_q1x, r_p1x); r_wy <= sub(r_q1y, r_p1y);
        r_vx <= sub(r_q2x, r_p1x); r_vy <= sub(r_q2y, r_p1y);
        r_ux <= sub(r_p1x, r_q1x); r_uy <= sub(r_p1y, r_q1y);
        r_tx <= sub(r_p2x, r_q1x); r_ty <= sub(r_p2y, r_q1y);
    end

    // stage c: twelve products
    function automatic t_prod mul(t_diff a, t_diff b);
        return t_prod'(a) * t_prod'(b);
    endfunction

    logic   r_vc, r_cboxes, r_cbq1, r_cbq2, r_cbp1, r_cbp2;
    t_coord r_cp1x, r_cp1y, r_cp2x, r_cp2y, r_cq1x, r_cq1y, r_cq2x, r_cq2y;
    t_diff  r_cdx, r_cdy;
    t_prod  r_m0, r_m1, r_m2, r_m3, r_m4, r_m5, r_m6, r_m7, r_m8, r_m9, r_m10, r_m11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else begin
            r_vc <= r_vb;
        end
        r_cboxes <= r_boxes;
        r_cbq1 <= r_bq1; r_cbq2 <= r_bq2; r_cbp1 <= r_bp1; r_cbp2 <= r_bp2;
        r_cp1x <= r_bp1x; r_cp1y <= r_bp1y; r_cp2x <= r_bp2x; r_cp2y <= r_bp2y;
        r_cq1x <= r_bq1x; r_cq1y <= r_bq1y; r_cq2x <= r_bq2x; r_cq2y <= r_bq2y;
        r_cdx <= r_dx; r_cdy <= r_dy;
        r_m0  <= mul(r_dx, r_wy); r_m1  <= mul(r_dy, r_wx);
        r_m2  <= mul(r_dx, r_vy); r_m3  <= mul(r_dy, r_vx);
        r_m4  <= mul(r_ex, r_uy); r_m5  <= mul(r_ey, r_ux);
        r_m6  <= mul(r_ex, r_ty); r_m7  <= mul(r_ey, r_tx);
        r_m8  <= mul(r_dx, r_ey); r_m9  <= mul(r_dy, r_ex);
        r_m10 <= mul(r_wx, r_ey); r_m11 <= mul(r_wy, r_ex);
    end

    // stage d: cross products
    function automatic t_cross xsub(t_prod a, t_prod b);
        return t_cross'(a) - t_cross'(b);
    endfunction

    logic   r_vd, r_dboxes, r_dbq1, r_dbq2, r_dbp1, r_dbp2;
    t_coord r_dp1x, r_dp1y, r_dp2x, r_dp2y, r_dq1x, r_dq1y, r_dq2x, r_dq2y;
    t_diff  r_ddx, r_ddy;
    t_cross r_pq1, r_pq2, r_qp1, r_qp2, r_den, r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else begin
            r_vd <= r_vc;
        end
        r_dboxes <= r_cboxes;
        r_dbq1 <= r_cbq1; r_dbq2 <= r_cbq2; r_dbp1 <= r_cbp1; r_dbp2 <= r_cbp2;
        r_dp1x <= r_cp1x; r_dp1y <= r_cp1y; r_dp2x <= r_cp2x; r_dp2y <= r_cp2y;
        r_dq1x <= r_cq1x; r_dq1y <= r_cq1y; r_dq2x <= r_cq2x; r_dq2y <= r_cq2y;
        r_ddx <= r_cdx; r_ddy <= r_cdy;
        r_pq1 <= xsub(r_m0, r_m1);
        r_pq2 <= xsub(r_m2, r_m3);
        r_qp1 <= xsub(r_m4, r_m5);
        r_qp2 <= xsub(r_m6, r_m7);
        r_den <= xsub(r_m8, r_m9);
        r_num <= xsub(r_m10, r_m11);
    end

    // stage e: classification
    logic   z1, z2, z3, z4, rej, touch;
    t_pay   n_pay;
    t_cross den_n, num_n;
    t_diff  ax, ay;

    always_comb begin
        z1 = (r_pq1 == '0);
        z2 = (r_pq2 == '0);
        z3 = (r_qp1 == '0);
        z4 = (r_qp2 == '0);
        rej = !r_dboxes
            || (!z1 && !z2 && (r_pq1[CROSS_BITS-1] == r_pq2[CROSS_BITS-1]))
            || (!z3 && !z4 && (r_qp1[CROSS_BITS-1] == r_qp2[CROSS_BITS-1]));
        den_n = r_den[CROSS_BITS-1] ? -r_den : r_den;
        num_n = r_den[CROSS_BITS-1] ? -r_num : r_num;
        ax    = r_ddx[DIFF_BITS-1] ? -r_ddx : r_ddx;
        ay    = r_ddy[DIFF_BITS-1] ? -r_ddy : r_ddy;
        touch = 1'b0;
        n_pay = '0;
        n_pay.kind = KIND_NONE;
        n_pay.p1x  = r_dp1x;
        n_pay.p1y  = r_dp1y;
        n_pay.negx = r_ddx[DIFF_BITS-1];
        n_pay.negy = r_ddy[DIFF_BITS-1];
        n_pay.bad  = (den_n == '0) || num_n[CROSS_BITS-1] || (num_n >= den_n);
        if (rej) begin
            n_pay.kind = KIND_NONE;
        end else if (z1 && z2 && z3 && z4) begin
            n_pay.kind = KIND_OVERLAP;
            priority if (r_dbq1 && r_dbq2) begin
                n_pay.fx = r_dq1x; n_pay.fy = r_dq1y; n_pay.sx = r_dq2x; n_pay.sy = r_dq2y;
            end else if (r_dbp1 && r_dbp2) begin
                n_pay.fx = r_dp1x; n_pay.fy = r_dp1y; n_pay.sx = r_dp2x; n_pay.sy = r_dp2y;
            end else if (r_dbq1 && r_dbp1) begin
                n_pay.fx = r_dq1x; n_pay.fy = r_dq1y; n_pay.sx = r_dp1x; n_pay.sy = r_dp1y;
                touch = !r_dbq2 && !r_dbp2;
            end else if (r_dbq1 && r_dbp2) begin
                n_pay.fx = r_dq1x; n_pay.fy = r_dq1y; n_pay.sx = r_dp2x; n_pay.sy = r_dp2y;
                touch = !r_dbq2 && !r_dbp1;
            end else if (r_dbq2 && r_dbp1) begin
                n_pay.fx = r_dq2x; n_pay.fy = r_dq2y; n_pay.sx = r_dp1x; n_pay.sy = r_dp1y;
                touch = !r_dbq1 && !r_dbp2;
            end else if (r_dbq2 && r_dbp2) begin
                n_pay.fx = r_dq2x; n_pay.fy = r_dq2y; n_pay.sx = r_dp2x; n_pay.sy = r_dp2y;
                touch = !r_dbq1 && !r_dbp1;
            end else begin
                n_pay.kind = KIND_NONE;
            end
            if (touch && (n_pay.fx == n_pay.sx) && (n_pay.fy == n_pay.sy)) begin
                n_pay.kind = KIND_POINT;
                n_pay.sx   = '0;
                n_pay.sy   = '0;
            end
        end else begin
            n_pay.kind = KIND_POINT;
            priority if (z4) begin
                n_pay.fx = r_dp2x; n_pay.fy = r_dp2y;
            end else if (z3) begin
                n_pay.fx = r_dp1x; n_pay.fy = r_dp1y;
            end else if (z2) begin
                n_pay.fx = r_dq2x; n_pay.fy = r_dq2y;
            end else if (z1) begin
                n_pay.fx = r_dq1x; n_pay.fy = r_dq1y;
            end else begin
                n_pay.proper = 1'b1;
            end
        end
    end

    logic  r_ve;
    t_pay  r_pay;
    t_mag  r_nm, r_dm;
    t_diff r_ax, r_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else begin
            r_ve <= r_vd;
        end
        r_pay <= n_pay;
        r_nm  <= num_n[MAG_BITS-1:0];
        r_dm  <= den_n[MAG_BITS-1:0];
        r_ax  <= ax;
        r_ay  <= ay;
    end

    // stage f: scale numerator by each axis span, as two half-width partial products
    logic r_vf;
    t_pay r_fpay;
    t_mag r_fdm;
    logic [2*DIFF_BITS-1:0] r_pxl, r_pxh, r_pyl, r_pyh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else begin
            r_vf <= r_ve;
        end
        r_fpay <= r_pay;
        r_fdm  <= r_dm;
        r_pxl  <= (2*DIFF_BITS)'(r_nm[DIFF_BITS-1:0])
                * (2*DIFF_BITS)'(unsigned'(r_ax));
        r_pxh  <= (2*DIFF_BITS)'(r_nm[MAG_BITS-1:DIFF_BITS])
                * (2*DIFF_BITS)'(unsigned'(r_ax));
        r_pyl  <= (2*DIFF_BITS)'(r_nm[DIFF_BITS-1:0])
                * (2*DIFF_BITS)'(unsigned'(r_ay));
        r_pyh  <= (2*DIFF_BITS)'(r_nm[MAG_BITS-1:DIFF_BITS])
                * (2*DIFF_BITS)'(unsigned'(r_ay));
    end

    // stage g: dividend with rounding bias, divisor aligned to top quotient bit
    t_cell r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= r_vf;
        end
        r_cell.pay <= r_fpay;
        r_cell.rx  <= (t_num'(r_pxh) << (DIFF_BITS + 1)) + (t_num'(r_pxl) << 1)
                    + t_num'(r_fdm) - t_num'(r_fpay.negx);
        r_cell.ry  <= (t_num'(r_pyh) << (DIFF_BITS + 1)) + (t_num'(r_pyl) << 1)
                    + t_num'(r_fdm) - t_num'(r_fpay.negy);
        r_cell.d   <= t_num'(r_fdm) << COORD_BITS;
        r_cell.qx  <= '0;
        r_cell.qy  <= '0;
    end

    assign o_cell = r_cell;

endmodule

// ----- rtl/sic_cell.sv -----
module sic_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sic_pkg::t_cell i_cell,
    output sic_pkg::t_cell o_cell
);
    import sic_pkg::*;

    logic  gx, gy;
    t_cell n_cell, r_cell;

    // one restoring quotient bit per axis
    always_comb begin
        gx = (i_cell.rx >= i_cell.d);
        gy = (i_cell.ry >= i_cell.d);
        n_cell     = i_cell;
        n_cell.rx  = gx ? (i_cell.rx - i_cell.d) : i_cell.rx;
        n_cell.ry  = gy ? (i_cell.ry - i_cell.d) : i_cell.ry;
        n_cell.d   = i_cell.d >> 1;
        n_cell.qx  = {i_cell.qx[COORD_BITS-2:0], gx};
        n_cell.qy  = {i_cell.qy[COORD_BITS-2:0], gy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
        r_cell.pay <= n_cell.pay;
        r_cell.rx  <= n_cell.rx;
        r_cell.ry  <= n_cell.ry;
        r_cell.d   <= n_cell.d;
        r_cell.qx  <= n_cell.qx;
        r_cell.qy  <= n_cell.qy;
    end

    assign o_cell = r_cell;

endmodule

// ----- rtl/segment_intersection_classify.sv -----
// channel   | ports                               | handshake
// ----------+-------------------------------------+----------------------------------
// pair in   | i_a_*, i_b_* (signed coordinates)   | i_start while o_busy low
// result    | o_kind, o_proper, o_first_*, o_sec* | o_strobe, one cycle, no back-off
//
// one pair per cycle, every cycle; o_busy is always low
// the pipeline is seven front stages, one divider cell per quotient bit
// and one output register
// the divider cell chain sets the latency, not the rate
// synchronous active-low reset empties the pipeline; nothing else is held
// the receiver cannot stall, so every result leaves exactly once
module segment_intersection_classify (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic signed [sic_pkg::COORD_BITS-1:0] i_a_start_x,
    input  logic signed [sic_pkg::COORD_BITS-1:0] i_a_start_y,
    input  logic signed [sic_pkg::COORD_BITS-1:0] i_a_end_x,
    input  logic signed [sic_pkg::COORD_BITS-1:0] i_a_end_y,
    input  logic signed [sic_pkg::COORD_BITS-1:0] i_b_start_x,
    input  logic signed [sic_pkg::COORD_BITS-1:0] i_b_start_y,
    input  logic signed [sic_pkg::COORD_BITS-1:0] i_b_end_x,
    input  logic signed [sic_pkg::COORD_BITS-1:0] i_b_end_y,
    output logic                            o_strobe,
    output logic [1:0]                      o_kind,
    output logic                            o_proper,
    output logic signed [sic_pkg::COORD_BITS-1:0] o_first_x,
    output logic signed [sic_pkg::COORD_BITS-1:0] o_first_y,
    output logic signed [sic_pkg::COORD_BITS-1:0] o_second_x,
    output logic signed [sic_pkg::COORD_BITS-1:0] o_second_y
);
    import sic_pkg::*;

    // no state between transactions, so never busy
    assign o_busy = 1'b0;

    t_cell chain [0:COORD_BITS];

    // bounding boxes, orientations, classification and scaling
    sic_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_p1x   (i_a_start_x),
        .i_p1y   (i_a_start_y),
        .i_p2x   (i_a_end_x),
        .i_p2y   (i_a_end_y),
        .i_q1x   (i_b_start_x),
        .i_q1y   (i_b_start_y),
        .i_q2x   (i_b_end_x),
        .i_q2y   (i_b_end_y),
        .o_cell  (chain[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar g = 0; g < COORD_BITS; g++) begin : g_cell
        sic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (chain[g]),
            .o_cell  (chain[g+1])
        );
    end

    // crossing point: start of a plus signed rounded offset
    t_cell last;
    t_diff offx, offy;
    t_coord n_fx, n_fy;

    always_comb begin
        last = chain[COORD_BITS];
        offx = last.pay.negx ? -t_diff'({1'b0, last.qx}) : t_diff'({1'b0, last.qx});
        offy = last.pay.negy ? -t_diff'({1'b0, last.qy}) : t_diff'({1'b0, last.qy});
        n_fx = last.pay.fx;
        n_fy = last.pay.fy;
        if (last.pay.proper) begin
            if (last.pay.bad) begin
                n_fx = last.pay.p1x;
                n_fy = last.pay.p1y;
            end else begin
                n_fx = t_coord'(t_diff'(last.pay.p1x) + offx);
                n_fy = t_coord'(t_diff'(last.pay.p1y) + offy);
            end
        end
    end

    logic   r_strobe, r_proper;
    t_kind  r_kind;
    t_coord r_fx, r_fy, r_sx, r_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= last.valid;
        end
        r_kind   <= last.pay.kind;
        r_proper <= last.pay.proper;
        r_fx     <= n_fx;
        r_fy     <= n_fy;
        r_sx     <= last.pay.sx;
        r_sy     <= last.pay.sy;
    end

    assign o_strobe   = r_strobe;
    assign o_kind     = r_kind;
    assign o_proper   = r_proper;
    assign o_first_x  = r_fx;
    assign o_first_y  = r_fy;
    assign o_second_x = r_sx;
    assign o_second_y = r_sy;

endmodule

// ----- rtl/sic_checker.sv -----
module sic_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_busy,
    input logic                                  o_strobe,
    input logic [1:0]                            o_kind,
    input logic                                  o_proper,
    input logic signed [sic_pkg::COORD_BITS-1:0] o_first_x,
    input logic signed [sic_pkg::COORD_BITS-1:0] o_first_y,
    input logic signed [sic_pkg::COORD_BITS-1:0] o_second_x,
    input logic signed [sic_pkg::COORD_BITS-1:0] o_second_y
);
    import sic_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy raised");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_NONE) |->
        !o_proper && (o_first_x == '0) && (o_first_y == '0)
        && (o_second_x == '0) && (o_second_y == '0)) else $error("none not cleared");

    a_proper_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_proper |-> (o_kind == KIND_POINT)) else $error("proper not point");

    a_point_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_POINT) |-> (o_second_x == '0) && (o_second_y == '0))
        else $error("point with second");

endmodule

bind segment_intersection_classify sic_checker u_sic_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_busy     (o_busy),
    .o_strobe   (o_strobe),
    .o_kind     (o_kind),
    .o_proper   (o_proper),
    .o_first_x  (o_first_x),
    .o_first_y  (o_first_y),
    .o_second_x (o_second_x),
    .o_second_y (o_second_y)
);

// ----- test/segment_intersection_classify_checker.sv -----
module segment_intersection_classify_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  sic_pkg::t_coord i_ax1, i_ay1, i_ax2, i_ay2,
    input  sic_pkg::t_coord i_bx1, i_by1, i_bx2, i_by2,
    input  logic            i_strobe,
    input  logic [1:0]      i_kind,
    input  logic            i_proper,
    input  sic_pkg::t_coord i_fx, i_fy, i_sx, i_sy,
    output int              o_errors,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sic_pkg::*;

    typedef struct {
        t_kind  kind;
        logic   proper;
        t_coord fx, fy, sx, sy;
    } t_answer;

    t_answer answers_due[$];

    function automatic int sgn(longint signed v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic int side(longint signed px, longint signed py, longint signed qx,
                                longint signed qy, longint signed rx, longint signed ry);
        return sgn((qx - px) * (ry - py) - (qy - py) * (rx - px));
    endfunction

    function automatic bit boxed(longint signed ax, longint signed ay, longint signed bx,
                                 longint signed by, longint signed px, longint signed py);
        return px >= ((ax < bx) ? ax : bx) && px <= ((ax < bx) ? bx : ax)
            && py >= ((ay < by) ? ay : by) && py <= ((ay < by) ? by : ay);
    endfunction

    // nearest grid offset of num/den * delta, ties toward plus infinity
    function automatic longint signed round_offset(logic signed [127:0] num,
                                                   logic signed [127:0] den,
                                                   longint signed delta);
        logic signed [127:0] t;
        logic signed [127:0] q;
        t = 2 * num * delta + den;
        q = t / (2 * den);
        if (q * 2 * den > t) q = q - 1;
        return longint'(q);
    endfunction

    function automatic t_answer classify(t_coord ax1, t_coord ay1, t_coord ax2, t_coord ay2,
                                         t_coord bx1, t_coord by1, t_coord bx2, t_coord by2);
        t_answer r;
        longint signed p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y, dx, dy, ex, ey;
        int pq1, pq2, qp1, qp2;
        bit bq1, bq2, bp1, bp2, touch;
        logic signed [127:0] den, num;
        p1x = ax1; p1y = ay1; p2x = ax2; p2y = ay2;
        q1x = bx1; q1y = by1; q2x = bx2; q2y = by2;
        r = '{KIND_NONE, 1'b0, '0, '0, '0, '0};
        if (((p1x < p2x) ? p1x : p2x) > ((q1x > q2x) ? q1x : q2x) ||
            ((p1x > p2x) ? p1x : p2x) < ((q1x < q2x) ? q1x : q2x) ||
            ((p1y < p2y) ? p1y : p2y) > ((q1y > q2y) ? q1y : q2y) ||
            ((p1y > p2y) ? p1y : p2y) < ((q1y < q2y) ? q1y : q2y)) return r;
        pq1 = side(p1x, p1y, p2x, p2y, q1x, q1y);
        pq2 = side(p1x, p1y, p2x, p2y, q2x, q2y);
        if (pq1 * pq2 > 0) return r;
        qp1 = side(q1x, q1y, q2x, q2y, p1x, p1y);
        qp2 = side(q1x, q1y, q2x, q2y, p2x, p2y);
        if (qp1 * qp2 > 0) return r;
        if (pq1 == 0 && pq2 == 0 && qp1 == 0 && qp2 == 0) begin
            bq1 = boxed(p1x, p1y, p2x, p2y, q1x, q1y);
            bq2 = boxed(p1x, p1y, p2x, p2y, q2x, q2y);
            bp1 = boxed(q1x, q1y, q2x, q2y, p1x, p1y);
            bp2 = boxed(q1x, q1y, q2x, q2y, p2x, p2y);
            touch = 0;
            r.kind = KIND_OVERLAP;
            if (bq1 && bq2) begin
                r.fx = bx1; r.fy = by1; r.sx = bx2; r.sy = by2;
            end else if (bp1 && bp2) begin
                r.fx = ax1; r.fy = ay1; r.sx = ax2; r.sy = ay2;
            end else if (bq1 && bp1) begin
                r.fx = bx1; r.fy = by1; r.sx = ax1; r.sy = ay1; touch = !bq2 && !bp2;
            end else if (bq1 && bp2) begin
                r.fx = bx1; r.fy = by1; r.sx = ax2; r.sy = ay2; touch = !bq2 && !bp1;
            end else if (bq2 && bp1) begin
                r.fx = bx2; r.fy = by2; r.sx = ax1; r.sy = ay1; touch = !bq1 && !bp2;
            end else if (bq2 && bp2) begin
                r.fx = bx2; r.fy = by2; r.sx = ax2; r.sy = ay2; touch = !bq1 && !bp1;
            end else begin
                r.kind = KIND_NONE;
            end
            if (r.kind == KIND_OVERLAP && touch && r.fx == r.sx && r.fy == r.sy) begin
                r.kind = KIND_POINT; r.sx = '0; r.sy = '0;
            end
            return r;
        end
        r.kind = KIND_POINT;
        if (pq1 == 0 || pq2 == 0 || qp1 == 0 || qp2 == 0) begin
            // last endpoint on the other line wins
            if (pq1 == 0) begin r.fx = bx1; r.fy = by1; end
            if (pq2 == 0) begin r.fx = bx2; r.fy = by2; end
            if (qp1 == 0) begin r.fx = ax1; r.fy = ay1; end
            if (qp2 == 0) begin r.fx = ax2; r.fy = ay2; end
            return r;
        end
        dx = p2x - p1x; dy = p2y - p1y; ex = q2x - q1x; ey = q2y - q1y;
        den = 128'(dx) * ey - 128'(dy) * ex;
        num = 128'(q1x - p1x) * ey - 128'(q1y - p1y) * ex;
        r.proper = 1'b1;
        if (den < 0) begin den = -den; num = -num; end
        if (den == 0 || num < 0 || num >= den) begin
            r.fx = ax1; r.fy = ay1;
        end else begin
            r.fx = t_coord'(p1x + round_offset(num, den, dx));
            r.fy = t_coord'(p1y + round_offset(num, den, dy));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = answers_due.size();

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && i_start && !i_busy)
            answers_due.push_back(classify(i_ax1, i_ay1, i_ax2, i_ay2,
                                           i_bx1, i_by1, i_bx2, i_by2));
        if (i_rst_n && i_strobe) begin
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                e = answers_due.pop_front();
                if (i_kind !== e.kind) report_mismatch("kind", i_kind, e.kind);
                if (i_proper !== e.proper) report_mismatch("proper", i_proper, e.proper);
                if (i_fx !== e.fx) report_mismatch("first_x", i_fx, e.fx);
                if (i_fy !== e.fy) report_mismatch("first_y", i_fy, e.fy);
                if (i_sx !== e.sx) report_mismatch("second_x", i_sx, e.sx);
                if (i_sy !== e.sy) report_mismatch("second_y", i_sy, e.sy);
            end
        end
    end
endmodule

// ----- test/segment_intersection_classify_test.sv -----
module segment_intersection_classify_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sic_pkg::*;

    localparam int RANDOM_PAIRS = 530;
    localparam int STALL_LIMIT  = 2000;

    logic   i_clk = 0, i_rst_n = 0, i_start = 0;
    logic   o_busy, o_strobe, o_proper;
    logic [1:0] o_kind;
    t_coord ax1 = '0, ay1 = '0, ax2 = '0, ay2 = '0;
    t_coord bx1 = '0, by1 = '0, bx2 = '0, by2 = '0;
    t_coord o_fx, o_fy, o_sx, o_sy;
    int     errors, pending, quiet_cycles;

    always #4 i_clk = ~i_clk;

    segment_intersection_classify uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_a_start_x(ax1), .i_a_start_y(ay1), .i_a_end_x(ax2), .i_a_end_y(ay2),
        .i_b_start_x(bx1), .i_b_start_y(by1), .i_b_end_x(bx2), .i_b_end_y(by2),
        .o_strobe(o_strobe), .o_kind(o_kind), .o_proper(o_proper),
        .o_first_x(o_fx), .o_first_y(o_fy), .o_second_x(o_sx), .o_second_y(o_sy)
    );

    segment_intersection_classify_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_ax1(ax1), .i_ay1(ay1), .i_ax2(ax2), .i_ay2(ay2),
        .i_bx1(bx1), .i_by1(by1), .i_bx2(bx2), .i_by2(by2),
        .i_strobe(o_strobe), .i_kind(o_kind), .i_proper(o_proper),
        .i_fx(o_fx), .i_fy(o_fy), .i_sx(o_sx), .i_sy(o_sy),
        .o_errors(errors), .o_pending(pending)
    );

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // one transaction: hold start until the block takes it
    task automatic send_pair(t_coord a1x, t_coord a1y, t_coord a2x, t_coord a2y,
                             t_coord b1x, t_coord b1y, t_coord b2x, t_coord b2y);
        ax1 <= a1x; ay1 <= a1y; ax2 <= a2x; ay2 <= a2y;
        bx1 <= b1x; by1 <= b1y; bx2 <= b2x; by2 <= b2y;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic pause_sender();
        i_start <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge i_clk);
    endtask

    function automatic t_coord any_coord();
        return t_coord'($urandom);
    endfunction

    // small offset around a base so that boxes overlap often
    function automatic t_coord near(t_coord base, int span);
        return t_coord'(base + $signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_random(int shape);
        t_coord cx, cy, x1, y1, x2, y2, sx, sy;
        int k, m, n;
        cx = any_coord(); cy = any_coord();
        case (shape)
            0: send_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                         any_coord(), any_coord(), any_coord(), any_coord());
            1: send_pair(near(cx, 40), near(cy, 40), near(cx, 40), near(cy, 40),
                         near(cx, 40), near(cy, 40), near(cx, 40), near(cy, 40));
            2: begin
                // collinear points along one direction
                sx = t_coord'($urandom_range(0, 6) - 3);
                sy = t_coord'($urandom_range(0, 6) - 3);
                k = $urandom_range(0, 8); m = $urandom_range(0, 8); n = $urandom_range(0, 8);
                send_pair(cx, cy, t_coord'(cx + sx * k), t_coord'(cy + sy * k),
                          t_coord'(cx + sx * m), t_coord'(cy + sy * m),
                          t_coord'(cx + sx * n), t_coord'(cy + sy * n));
            end
            3: begin
                // endpoint touch, shared point
                x1 = near(cx, 1000); y1 = near(cy, 1000);
                x2 = near(cx, 1000); y2 = near(cy, 1000);
                send_pair(x1, y1, cx, cy, cx, cy, x2, y2);
            end
            default: begin
                // long crossing through a centre
                sx = t_coord'($urandom_range(0, 200000) - 100000);
                sy = t_coord'($urandom_range(0, 200000) - 100000);
                x1 = t_coord'($urandom_range(0, 200000) - 100000);
                y1 = t_coord'($urandom_range(0, 200000) - 100000);
                send_pair(sx, sy, -sx, -sy, x1, y1, t_coord'(-x1 + 1), -y1);
            end
        endcase
    endtask

    localparam t_coord MAXC = t_coord'({1'b0, {(COORD_BITS-1){1'b1}}});
    localparam t_coord MINC = t_coord'({1'b1, {(COORD_BITS-1){1'b0}}});

    initial begin
        int i;
        quiet_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, disjoint boxes, same-side rejection, crossings,
        // ties in rounding, touches, collinear cases, degenerate segments
        send_pair(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
        send_pair(MINC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC);
        send_pair(0, 0, 1, 1, 5, 5, 6, 7);
        send_pair(0, 0, 10, 0, 0, 1, 10, 2);
        send_pair(0, 0, 2, 2, 0, 2, 2, 0);
        send_pair(0, 0, 1, 0, 0, 1, 1, -1);
        send_pair(0, 0, 3, 1, 0, 1, 3, 0);
        send_pair(0, 0, -3, -1, 0, -1, -3, 0);
        send_pair(0, 0, 4, 0, 2, 0, 2, 5);
        send_pair(0, 0, 4, 4, 4, 4, 8, 0);
        send_pair(0, 0, 10, 0, 2, 0, 5, 0);
        send_pair(2, 0, 5, 0, 0, 0, 10, 0);
        send_pair(0, 0, 5, 0, 3, 0, 9, 0);
        send_pair(0, 0, 5, 0, 9, 0, 3, 0);
        send_pair(5, 0, 0, 0, 3, 0, 9, 0);
        send_pair(5, 0, 0, 0, 9, 0, 3, 0);
        send_pair(0, 0, 5, 5, 5, 5, 9, 9);
        send_pair(0, 0, 5, 0, 6, 0, 9, 0);
        send_pair(3, 3, 3, 3, 3, 3, 3, 3);
        send_pair(3, 3, 3, 3, 0, 0, 6, 6);
        send_pair(3, 3, 3, 3, 4, 4, 4, 4);
        send_pair(MAXC, MAXC, MAXC, MAXC, MINC, MINC, MAXC, MAXC);
        send_pair(-1, -1, -1, -1, -1, -1, -1, -1);

        for (i = 0; i < RANDOM_PAIRS; i++) begin
            send_random($urandom_range(0, 5));
            // no sender gaps in the last part of the run
            if (i < RANDOM_PAIRS - 60 && $urandom_range(0, 3) == 0) pause_sender();
        end
        i_start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
